// ===== src/hcb_pkg.sv =====
// Shared constants, types and state codes of the prefix-code builder.
package hcb_pkg;

    localparam int MAX_SYMBOLS = 32;
    localparam int WEIGHT_BITS = 32;
    localparam int NODE_COUNT  = 2 * MAX_SYMBOLS - 1;
    localparam int IDX_W       = $clog2(NODE_COUNT);
    localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int TAG_W       = $clog2(MAX_SYMBOLS);
    localparam int SUM_W       = WEIGHT_BITS + TAG_W;
    localparam int CODE_W      = 63;
    localparam int LEN_W       = 6;
    localparam int SYM_W       = 6;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 80;

    typedef struct packed {
        logic [SUM_W-1:0] weight;
        logic [TAG_W-1:0] tag;
    } wt_entry_t;

    typedef struct packed {
        logic [IDX_W-1:0] parent;
        logic             side;
    } link_entry_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_MERGE_LO,
        ST_MERGE_HI,
        ST_WALK,
        ST_STEP,
        ST_OUT
    } state_t;

endpackage

// ===== src/huffman_code_builder_core.sv =====
// Top level of the prefix-code builder: weight load, tree build, code walk.
//
//  channel | dir | tdata                                  | tlast        | tuser
//  s_      | in  | weight[31:0]                           | final_symbol | -
//  m_      | out | symbol_index, code_bits, code_length   | last_code    | dropped_symbols
//
// Load: one item per cycle. Build: each merge scans live nodes through the
// node memory, 31 merges at most. Output: each code bit passes the walk and step
// states, each code the walk and output states; output is stalled by m_tready.
// No input is taken from the final item until the last code has been taken.
// Reset clears the state, live flags, symbol count and overflow flag; node memories need no clearing.
module huffman_code_builder_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hcb_pkg::S_DATA_W-1:0] s_tdata,  // [31:0] weight
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [5:0] symbol_index, [68:6] code_bits, [74:69] code_length, [79:75] zero
    output logic [hcb_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast,
    output logic                         m_tuser   // dropped_symbols
);

    hcb_pkg::state_t state_reg, state_next;

    hcb_pkg::wt_entry_t   wt_mem   [hcb_pkg::NODE_COUNT];
    hcb_pkg::link_entry_t link_mem [hcb_pkg::NODE_COUNT];

    hcb_pkg::wt_entry_t   wt_q;
    hcb_pkg::link_entry_t link_q;

    logic                         wt_we;
    logic [hcb_pkg::IDX_W-1:0]    wt_waddr;
    hcb_pkg::wt_entry_t           wt_wdata;
    logic                         link_we;
    logic [hcb_pkg::IDX_W-1:0]    link_waddr;
    hcb_pkg::link_entry_t         link_wdata;

    logic [hcb_pkg::NODE_COUNT-1:0] live_reg, live_next;
    logic [hcb_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                           ovf_reg, ovf_next;
    logic [hcb_pkg::IDX_W-1:0]      next_reg, next_next;
    logic [hcb_pkg::CNT_W-1:0]      nlive_reg, nlive_next;

    logic [hcb_pkg::IDX_W-1:0]      scan_reg, scan_next;
    logic                           rdv_reg, rdv_next;
    logic [hcb_pkg::IDX_W-1:0]      rdi_reg, rdi_next;
    hcb_pkg::wt_entry_t             lo_reg, lo_next, hi_reg, hi_next;
    logic [hcb_pkg::IDX_W-1:0]      loi_reg, loi_next, hii_reg, hii_next;
    logic                           lok_reg, lok_next, hok_reg, hok_next;

    logic [hcb_pkg::CNT_W-1:0]      sym_reg, sym_next;
    logic [hcb_pkg::IDX_W-1:0]      node_reg, node_next;
    logic [hcb_pkg::CODE_W-1:0]     bits_reg, bits_next;
    logic [hcb_pkg::LEN_W-1:0]      len_reg, len_next;

    logic                      s_fire, m_fire, is_last, scan_done;
    logic [hcb_pkg::CNT_W-1:0] count_new;
    hcb_pkg::wt_entry_t        load_entry, merged;

    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;
    assign is_last   = (sym_reg + 1'b1) == count_reg;
    assign scan_done = (scan_reg == next_reg);
    assign count_new = (count_reg < hcb_pkg::CNT_W'(hcb_pkg::MAX_SYMBOLS))
                       ? count_reg + 1'b1 : count_reg;

    assign load_entry.weight = hcb_pkg::SUM_W'(s_tdata[hcb_pkg::WEIGHT_BITS-1:0]);
    assign load_entry.tag    = count_reg[hcb_pkg::TAG_W-1:0];
    assign merged.weight     = lo_reg.weight + hi_reg.weight;
    assign merged.tag        = (lo_reg.tag < hi_reg.tag) ? lo_reg.tag : hi_reg.tag;

    always_ff @(posedge aclk) begin
        if (wt_we) begin
            wt_mem[wt_waddr] <= wt_wdata;
        end
        wt_q <= wt_mem[scan_reg];
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q <= link_mem[node_reg];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hcb_pkg::ST_LOAD: begin
                if (s_fire && s_tlast) begin
                    state_next = (count_new > 1) ? hcb_pkg::ST_SCAN : hcb_pkg::ST_WALK;
                end
            end
            hcb_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = hcb_pkg::ST_MERGE_LO;
                end
            end
            hcb_pkg::ST_MERGE_LO: state_next = hcb_pkg::ST_MERGE_HI;
            hcb_pkg::ST_MERGE_HI: begin
                state_next = (nlive_reg > 2) ? hcb_pkg::ST_SCAN : hcb_pkg::ST_WALK;
            end
            hcb_pkg::ST_WALK: begin
                state_next = live_reg[node_reg] ? hcb_pkg::ST_OUT : hcb_pkg::ST_STEP;
            end
            hcb_pkg::ST_STEP: state_next = hcb_pkg::ST_WALK;
            hcb_pkg::ST_OUT: begin
                if (m_fire) begin
                    state_next = is_last ? hcb_pkg::ST_LOAD : hcb_pkg::ST_WALK;
                end
            end
            default: state_next = hcb_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        live_next  = live_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        next_next  = next_reg;
        nlive_next = nlive_reg;
        scan_next  = scan_reg;
        rdv_next   = 1'b0;
        rdi_next   = scan_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        loi_next   = loi_reg;
        hii_next   = hii_reg;
        lok_next   = lok_reg;
        hok_next   = hok_reg;
        sym_next   = sym_reg;
        node_next  = node_reg;
        bits_next  = bits_reg;
        len_next   = len_reg;
        wt_we      = 1'b0;
        wt_waddr   = count_reg[hcb_pkg::IDX_W-1:0];
        wt_wdata   = load_entry;
        link_we    = 1'b0;
        link_waddr = loi_reg;
        link_wdata = '{parent: next_reg, side: 1'b0};

        case (state_reg)
            hcb_pkg::ST_LOAD: begin
                if (s_fire) begin
                    if (count_reg < hcb_pkg::CNT_W'(hcb_pkg::MAX_SYMBOLS)) begin
                        wt_we = 1'b1;
                        live_next[count_reg[hcb_pkg::IDX_W-1:0]] = 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    count_next = count_new;
                    if (s_tlast) begin
                        next_next  = count_new[hcb_pkg::IDX_W-1:0];
                        nlive_next = count_new;
                        scan_next  = '0;
                        lok_next   = 1'b0;
                        hok_next   = 1'b0;
                        sym_next   = '0;
                        node_next  = '0;
                        bits_next  = '0;
                        len_next   = '0;
                    end
                end
            end
            hcb_pkg::ST_SCAN: begin
                if (!scan_done) begin
                    rdv_next  = live_reg[scan_reg];
                    scan_next = scan_reg + 1'b1;
                end
                if (rdv_reg) begin
                    if (!lok_reg || (wt_q < lo_reg)) begin
                        hi_next  = lo_reg;
                        hii_next = loi_reg;
                        hok_next = lok_reg;
                        lo_next  = wt_q;
                        loi_next = rdi_reg;
                        lok_next = 1'b1;
                    end else if (!hok_reg || (wt_q < hi_reg)) begin
                        hi_next  = wt_q;
                        hii_next = rdi_reg;
                        hok_next = 1'b1;
                    end
                end
            end
            hcb_pkg::ST_MERGE_LO: begin
                wt_we     = 1'b1;
                wt_waddr  = next_reg;
                wt_wdata  = merged;
                link_we   = 1'b1;
                live_next[loi_reg]  = 1'b0;
                live_next[hii_reg]  = 1'b0;
                live_next[next_reg] = 1'b1;
            end
            hcb_pkg::ST_MERGE_HI: begin
                link_we    = 1'b1;
                link_waddr = hii_reg;
                link_wdata = '{parent: next_reg, side: 1'b1};
                next_next  = next_reg + 1'b1;
                nlive_next = nlive_reg - 1'b1;
                scan_next  = '0;
                lok_next   = 1'b0;
                hok_next   = 1'b0;
            end
            hcb_pkg::ST_STEP: begin
                bits_next = bits_reg
                            | (hcb_pkg::CODE_W'(link_q.side) << len_reg);
                len_next  = len_reg + 1'b1;
                node_next = link_q.parent;
            end
            hcb_pkg::ST_OUT: begin
                if (m_fire) begin
                    if (is_last) begin
                        live_next  = '0;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end else begin
                        sym_next  = sym_reg + 1'b1;
                        node_next = hcb_pkg::IDX_W'(sym_reg + 1'b1);
                        bits_next = '0;
                        len_next  = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hcb_pkg::ST_LOAD;
            live_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            rdv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            live_reg  <= live_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            rdv_reg   <= rdv_next;
        end
        next_reg  <= next_next;
        nlive_reg <= nlive_next;
        scan_reg  <= scan_next;
        rdi_reg   <= rdi_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        loi_reg   <= loi_next;
        hii_reg   <= hii_next;
        lok_reg   <= lok_next;
        hok_reg   <= hok_next;
        sym_reg   <= sym_next;
        node_reg  <= node_next;
        bits_reg  <= bits_next;
        len_reg   <= len_next;
    end

    assign s_tready = (state_reg == hcb_pkg::ST_LOAD);
    assign m_tvalid = (state_reg == hcb_pkg::ST_OUT);
    assign m_tdata  = {5'd0, len_reg, bits_reg, hcb_pkg::SYM_W'(sym_reg)};
    assign m_tlast  = is_last;
    assign m_tuser  = ovf_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a code is pending");

    a_single_root: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones(live_reg) == 1)
        else $error("code emitted with more than one live node");

    a_scan_needs_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hcb_pkg::ST_MERGE_LO) |-> (lok_reg && hok_reg))
        else $error("merge without two live nodes");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= hcb_pkg::CNT_W'(hcb_pkg::MAX_SYMBOLS))
        else $error("symbol count beyond capacity");

endmodule

// ===== bench/huffman_code_builder_core_test.sv =====
// Testbench for the prefix-code builder: directed and random weight blocks checked against a local code model.
`timescale 1ns / 1ps
module huffman_code_builder_core_test;

    typedef struct packed {
        logic [31:0] weight;
        logic        fin;
    } weight_item_t;

    typedef struct packed {
        logic [hcb_pkg::SYM_W-1:0]  sym;
        logic [hcb_pkg::CODE_W-1:0] bits;
        logic [hcb_pkg::LEN_W-1:0]  len;
        logic                       last;
        logic                       dropped;
    } code_t;

    logic                         aclk = 0;
    logic                         aresetn = 0;
    logic                         s_tvalid = 0;
    logic                         s_tready;
    logic [hcb_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                         s_tlast = 0;
    logic                         m_tvalid;
    logic                         m_tready = 0;
    logic [hcb_pkg::M_DATA_W-1:0] m_tdata;
    logic                         m_tlast;
    logic                         m_tuser;

    huffman_code_builder_core DUT (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    weight_item_t pending_weights[$];
    code_t        expected_codes[$];
    int           errors = 0;
    bit           hold_sender = 0;
    bit           stimulus_done = 0;

    // block state of the code model
    logic [63:0]               blk_weight[hcb_pkg::NODE_COUNT];
    logic [hcb_pkg::TAG_W-1:0] blk_tag[hcb_pkg::NODE_COUNT];
    int                        blk_parent[hcb_pkg::NODE_COUNT];
    bit                        blk_side[hcb_pkg::NODE_COUNT];
    bit                        blk_live[hcb_pkg::NODE_COUNT];
    int                        blk_count = 0;
    bit                        blk_overflow = 0;

    function automatic bit node_before(int a, int b);
        if (blk_weight[a] != blk_weight[b])
            return blk_weight[a] < blk_weight[b];
        return blk_tag[a] < blk_tag[b];
    endfunction

    task automatic predict_codes(weight_item_t it);
        int nxt, live, lo, hi, n;
        code_t c;
        if (blk_count < hcb_pkg::MAX_SYMBOLS) begin
            blk_weight[blk_count] = {32'd0, it.weight};
            blk_tag[blk_count] = hcb_pkg::TAG_W'(blk_count);
            blk_live[blk_count] = 1;
            blk_count++;
        end else begin
            blk_overflow = 1;
        end
        if (!it.fin)
            return;
        nxt = blk_count;
        live = blk_count;
        while (live > 1) begin
            lo = -1;
            hi = -1;
            for (int i = 0; i < nxt; i++) begin
                if (!blk_live[i])
                    continue;
                if (lo < 0 || node_before(i, lo)) begin
                    hi = lo;
                    lo = i;
                end else if (hi < 0 || node_before(i, hi)) begin
                    hi = i;
                end
            end
            blk_live[lo] = 0;
            blk_live[hi] = 0;
            blk_parent[lo] = nxt;
            blk_parent[hi] = nxt;
            blk_side[lo] = 0;
            blk_side[hi] = 1;
            blk_weight[nxt] = blk_weight[lo] + blk_weight[hi];
            blk_tag[nxt] = blk_tag[lo] < blk_tag[hi] ? blk_tag[lo] : blk_tag[hi];
            blk_live[nxt] = 1;
            nxt++;
            live--;
        end
        for (int s = 0; s < blk_count; s++) begin
            c = '0;
            n = s;
            while (!blk_live[n] && c.len < 63) begin
                c.bits[c.len] = blk_side[n];
                c.len++;
                n = blk_parent[n];
            end
            c.sym = hcb_pkg::SYM_W'(s);
            c.last = (s + 1 == blk_count);
            c.dropped = blk_overflow;
            expected_codes.push_back(c);
        end
        for (int i = 0; i < hcb_pkg::NODE_COUNT; i++)
            blk_live[i] = 0;
        blk_count = 0;
        blk_overflow = 0;
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] random_weight();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: return $urandom_range(0, 3);
            2: return $urandom_range(0, 20);
            3: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_block(int n, int kind);
        weight_item_t it;
        for (int i = 0; i < n; i++) begin
            case (kind)
                0: it.weight = random_weight();
                1: it.weight = 32'hFFFF_FFFF;
                2: it.weight = 0;
                3: it.weight = 32'd1 << (i % 32);
                default: it.weight = 7;
            endcase
            it.fin = (i == n - 1);
            pending_weights.push_back(it);
        end
    endtask

    // driver
    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predict_codes('{weight: s_tdata, fin: s_tlast});
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 0;
                end else if (pending_weights.size() > 0 && !hold_sender) begin
                    weight_item_t it;
                    it = pending_weights.pop_front();
                    s_tdata <= it.weight;
                    s_tlast <= it.fin;
                    s_tvalid <= 1;
                    send_gap <= ($urandom_range(0, 3) == 0) ? random_gap() : 0;
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // monitor
    code_t got, want;
    int    stall_mode = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.sym = m_tdata[5:0];
                got.bits = m_tdata[68:6];
                got.len = m_tdata[74:69];
                got.last = m_tlast;
                got.dropped = m_tuser;
                if (expected_codes.size() == 0) begin
                    $display("%0t: unexpected code item %p", $time, got);
                    errors++;
                end else begin
                    want = expected_codes.pop_front();
                    if (got != want || m_tdata[79:75] != 0) begin
                        $display("%0t: code mismatch expected %p actual %p pad %h",
                                 $time, want, got, m_tdata[79:75]);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 2);
            m_tready <= stall_mode == 0 ? 1'b1 :
                        stall_mode == 1 ? ($urandom_range(0, 3) != 0) :
                        ($urandom_range(0, 9) == 0);
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int total;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        // directed blocks
        add_block(1, 0);
        add_block(2, 1);
        add_block(3, 2);
        add_block(4, 4);
        add_block(5, 3);
        wait (pending_weights.size() == 0 && expected_codes.size() == 0);
        // full-depth tree, then overflow with a dropped final item
        add_block(32, 3);
        add_block(34, 0);
        wait (pending_weights.size() == 0);
        hold_sender = 1;
        total = 0;
        while (total < 280) begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 10);
            add_block(n, $urandom_range(0, 9) == 0 ? $urandom_range(1, 4) : 0);
            total += n;
        end
        repeat (2) @(posedge aclk);
        wait (expected_codes.size() == 0 && !s_tvalid);
        hold_sender = 0;
        wait (pending_weights.size() == 0);
        @(posedge aclk);
        wait (!s_tvalid && expected_codes.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_codes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== huffman_code_builder_core.f =====
src/hcb_pkg.sv
src/huffman_code_builder_core.sv
bench/huffman_code_builder_core_test.sv
